// File: src/ell_pkg.sv
package ell_pkg;

  localparam int unsigned MaxOut = 6;
  localparam int unsigned MaxPiece = 4;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] col_t;
  typedef logic [2:0]  cnt_t;

  localparam col_t  WRAP_RESET = 16'd79;

  localparam byte_t CH_BSL    = 8'h5C;
  localparam byte_t CH_DOLLAR = 8'h24;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_BEL    = 8'h07;
  localparam byte_t CH_BS     = 8'h08;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_VT     = 8'h0B;
  localparam byte_t CH_FF     = 8'h0C;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_TILDE  = 8'h7E;
  localparam byte_t CH_A      = 8'h61;
  localparam byte_t CH_B      = 8'h62;
  localparam byte_t CH_F      = 8'h66;
  localparam byte_t CH_R      = 8'h72;
  localparam byte_t CH_T      = 8'h74;
  localparam byte_t CH_V      = 8'h76;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    cnt_t                   cnt;
  } burst_t;

endpackage

// File: src/ell_encode.sv
module ell_encode (
  input  logic           kind,
  input  ell_pkg::byte_t char_in,
  input  ell_pkg::col_t  column,
  input  ell_pkg::col_t  wrap_width,
  output ell_pkg::burst_t burst,
  output ell_pkg::col_t  column_nxt
);

  logic [ell_pkg::MaxPiece-1:0][7:0] piece;
  ell_pkg::cnt_t                     len;
  ell_pkg::col_t                     limit;
  logic [16:0]                       reach;
  logic                              fold;
  ell_pkg::col_t                     base;

  always_comb begin
    piece    = '0;
    piece[0] = ell_pkg::CH_BSL;
    len      = 3'd2;
    priority if (char_in == ell_pkg::CH_BSL) begin
      piece[1] = ell_pkg::CH_BSL;
    end else if (char_in == ell_pkg::CH_DOLLAR) begin
      piece[1] = ell_pkg::CH_DOLLAR;
    end else if (char_in == ell_pkg::CH_BEL) begin
      piece[1] = ell_pkg::CH_A;
    end else if (char_in == ell_pkg::CH_BS) begin
      piece[1] = ell_pkg::CH_B;
    end else if (char_in == ell_pkg::CH_FF) begin
      piece[1] = ell_pkg::CH_F;
    end else if (char_in == ell_pkg::CH_CR) begin
      piece[1] = ell_pkg::CH_R;
    end else if (char_in == ell_pkg::CH_TAB) begin
      piece[1] = ell_pkg::CH_T;
    end else if (char_in == ell_pkg::CH_VT) begin
      piece[1] = ell_pkg::CH_V;
    end else if (char_in < ell_pkg::CH_SPACE || char_in > ell_pkg::CH_TILDE) begin
      piece[1] = ell_pkg::CH_ZERO + {6'd0, char_in[7:6]};
      piece[2] = ell_pkg::CH_ZERO + {5'd0, char_in[5:3]};
      piece[3] = ell_pkg::CH_ZERO + {5'd0, char_in[2:0]};
      len      = 3'd4;
    end else begin
      piece[0] = char_in;
      len      = 3'd1;
    end
  end

  assign limit = (wrap_width == '0) ? 16'd1 : wrap_width;
  assign reach = {1'b0, column} + {14'd0, len};
  assign fold  = (kind == ell_pkg::KIND_CHAR) && (reach > {1'b0, limit});
  assign base  = fold ? '0 : column;

  always_comb begin
    burst = '0;
    if (kind == ell_pkg::KIND_EOL) begin
      burst.bytes[0] = ell_pkg::CH_DOLLAR;
      burst.cnt      = 3'd1;
      column_nxt     = '0;
    end else begin
      if (fold) begin
        burst.bytes[0] = ell_pkg::CH_BSL;
        burst.bytes[1] = ell_pkg::CH_LF;
        for (int i = 0; i < ell_pkg::MaxPiece; i++) begin
          burst.bytes[i+2] = piece[i];
        end
        burst.cnt = len + 3'd2;
      end else begin
        for (int i = 0; i < ell_pkg::MaxPiece; i++) begin
          burst.bytes[i] = piece[i];
        end
        burst.cnt = len;
      end
      column_nxt = base + {13'd0, len};
    end
  end

endmodule

// File: src/ell_emit.sv
module ell_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ell_pkg::burst_t  burst,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output ell_pkg::byte_t   out_char_out,
  output logic             out_last
);

  logic [ell_pkg::MaxOut-1:0][7:0] buf_r, buf_nxt;
  ell_pkg::cnt_t                   cnt_r, cnt_nxt;
  ell_pkg::cnt_t                   idx_r, idx_nxt;
  logic                            busy_r, busy_nxt;
  logic                            take;

  assign out_valid    = busy_r;
  assign out_char_out = buf_r[idx_r];
  assign out_last     = (idx_r == cnt_r - 3'd1);
  assign take         = busy_r && !out_stall;
  assign free         = !busy_r || (take && out_last);

  always_comb begin
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (load) begin
      buf_nxt  = burst.bytes;
      cnt_nxt  = burst.cnt;
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (take) begin
      if (out_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < cnt_r)) else $error("byte index past burst length");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != 3'd0 && cnt_r <= 3'd6)) else $error("burst length out of range");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free) else $error("burst loaded over pending bytes");

endmodule

// File: src/escaped_line_lister.sv
// Unambiguous line listing with folding. Each transfer on the input carries one
// byte of a line or an end-of-line mark; the output gives the listing one byte
// per transfer, with last set on the final byte of each input item. An input
// item yields 1 to 6 output bytes: 1 for a plain printable
// byte or an end-of-line, 2 for a letter escape, 4 for an octal escape, plus 2
// when a fold is inserted. The output port sets the rate, one byte per cycle
// while out_stall is low; the input register takes the next item while the
// current one drains, so the output runs without gaps. The first byte is
// offered once the input register hands the item to the free emit buffer.
// cfg_wdata is the wrap width (greatest column before a fold); 0 acts as 1.
// Change it only while idle; the running column is kept across a change.
module escaped_line_lister (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [7:0]          in_char_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_char_out,
  output logic                out_last
);

  ell_pkg::col_t   wrap_r;
  ell_pkg::col_t   column_r, column_nxt;
  logic            s1_valid_r, s1_valid_nxt;
  logic            s1_kind_r;
  ell_pkg::byte_t  s1_char_r;
  logic            accept;
  logic            load;
  logic            free;
  ell_pkg::burst_t burst;

  assign load     = s1_valid_r && free;
  assign in_stall = s1_valid_r && !free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= in_kind;
      s1_char_r <= in_char_in;
    end
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      column_r   <= '0;
      wrap_r     <= ell_pkg::WRAP_RESET;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (load) begin
        column_r <= column_nxt;
      end
      if (cfg_we) begin
        wrap_r <= cfg_wdata;
      end
    end
  end

  ell_encode u_encode (
    .kind       (s1_kind_r),
    .char_in    (s1_char_r),
    .column     (column_r),
    .wrap_width (wrap_r),
    .burst      (burst),
    .column_nxt (column_nxt)
  );

  ell_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .burst        (burst),
    .free         (free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && s1_kind_r == ell_pkg::KIND_EOL) |=> (column_r == '0))
    else $error("end of line left column set");

endmodule

// File: test/tb_escaped_line_lister.sv
module tb_escaped_line_lister;

  typedef struct {
    ell_pkg::byte_t ch;
    logic           last;
  } listed_byte_t;

  class listing_board;
    ell_pkg::col_t column;
    ell_pkg::col_t wrap;
    listed_byte_t  pending[$];
    int            errors;
    int            items;
    int            bytes_seen;
    int            folds;

    function new();
      column     = '0;
      wrap       = ell_pkg::WRAP_RESET;
      errors     = 0;
      items      = 0;
      bytes_seen = 0;
      folds      = 0;
    endfunction

    function void set_wrap(ell_pkg::col_t w);
      wrap = w;
    endfunction

    function void push_byte(ell_pkg::byte_t ch, logic last);
      listed_byte_t b;
      b.ch   = ch;
      b.last = last;
      pending.push_back(b);
    endfunction

    // Predict the listing bytes of one accepted transfer.
    function void note_item(logic kind, ell_pkg::byte_t ch);
      ell_pkg::byte_t piece[4];
      int             len;
      int             limit;
      int             i;
      items++;
      if (kind == ell_pkg::KIND_EOL) begin
        push_byte(ell_pkg::CH_DOLLAR, 1'b1);
        column = '0;
        return;
      end
      len      = 2;
      piece[0] = ell_pkg::CH_BSL;
      case (ch)
        ell_pkg::CH_BSL:    piece[1] = ell_pkg::CH_BSL;
        ell_pkg::CH_DOLLAR: piece[1] = ell_pkg::CH_DOLLAR;
        ell_pkg::CH_BEL:    piece[1] = ell_pkg::CH_A;
        ell_pkg::CH_BS:     piece[1] = ell_pkg::CH_B;
        ell_pkg::CH_FF:     piece[1] = ell_pkg::CH_F;
        ell_pkg::CH_CR:     piece[1] = ell_pkg::CH_R;
        ell_pkg::CH_TAB:    piece[1] = ell_pkg::CH_T;
        ell_pkg::CH_VT:     piece[1] = ell_pkg::CH_V;
        default: begin
          if (ch < ell_pkg::CH_SPACE || ch > ell_pkg::CH_TILDE) begin
            piece[1] = ell_pkg::CH_ZERO + {6'b0, ch[7:6]};
            piece[2] = ell_pkg::CH_ZERO + {5'b0, ch[5:3]};
            piece[3] = ell_pkg::CH_ZERO + {5'b0, ch[2:0]};
            len      = 4;
          end else begin
            piece[0] = ch;
            len      = 1;
          end
        end
      endcase
      limit = (wrap == 0) ? 1 : int'(wrap);
      if (int'(column) + len > limit) begin
        push_byte(ell_pkg::CH_BSL, 1'b0);
        push_byte(ell_pkg::CH_LF, 1'b0);
        column = '0;
        folds++;
      end
      for (i = 0; i < len; i++)
        push_byte(piece[i], i == len - 1);
      column = ell_pkg::col_t'(int'(column) + len);
    endfunction

    function void check_byte(ell_pkg::byte_t ch, logic last);
      listed_byte_t want;
      bytes_seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected listing byte: expected none, got %h last %b",
                 $time, ch, last);
        return;
      end
      want = pending.pop_front();
      if (want.ch !== ch) begin
        errors++;
        $display("%0t: char_out mismatch: expected %h, got %h", $time, want.ch, ch);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t: last mismatch: expected %b, got %b", $time, want.last, last);
      end
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_we       = 1'b0;
  logic [15:0] cfg_wdata    = '0;
  logic        in_valid     = 1'b0;
  logic        in_kind      = ell_pkg::KIND_CHAR;
  logic [7:0]  in_char_in   = '0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_char_out;
  logic        out_last;

  listing_board board = new();
  int           gap_pct    = 0;
  int           stall_pct  = 0;
  int           stall_run  = 0;
  int           widths_set = 0;

  escaped_line_lister dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_char_in   (in_char_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (stall_pct == 0) begin
      stall_run = 0;
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run = stall_run - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(1, 100) <= stall_pct) begin
      stall_run = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_byte(out_char_out, out_last);
  end

  task automatic send_item(logic kind, ell_pkg::byte_t ch);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_char_in <= ch;
    do @(posedge clk); while (in_stall);
    board.note_item(kind, ch);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic set_wrap(ell_pkg::col_t w);
    cfg_wdata <= w;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_wrap(w);
    widths_set++;
  endtask

  function automatic ell_pkg::byte_t pick_char();
    ell_pkg::byte_t escaped_set[8];
    int             r;
    escaped_set = '{ell_pkg::CH_BSL, ell_pkg::CH_DOLLAR, ell_pkg::CH_BEL, ell_pkg::CH_BS,
                    ell_pkg::CH_FF, ell_pkg::CH_CR, ell_pkg::CH_TAB, ell_pkg::CH_VT};
    r = $urandom_range(0, 9);
    if (r < 4)
      return ell_pkg::byte_t'($urandom_range(32, 126));
    else if (r < 6)
      return ell_pkg::byte_t'($urandom_range(0, 255));
    else if (r < 8)
      return escaped_set[$urandom_range(0, 7)];
    else if (r == 8)
      return ell_pkg::byte_t'($urandom_range(0, 31));
    else
      return ell_pkg::byte_t'($urandom_range(127, 255));
  endfunction

  task automatic run_lines(int count, int eol_odds);
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0)
        drain();
      if ($urandom_range(1, eol_odds) == 1)
        send_item(ell_pkg::KIND_EOL, ell_pkg::byte_t'($urandom_range(0, 255)));
      else
        send_item(ell_pkg::KIND_CHAR, pick_char());
    end
  endtask

  initial begin
    ell_pkg::byte_t directed[14];
    int             p;
    directed = '{8'h00, 8'hFF, ell_pkg::CH_SPACE, ell_pkg::CH_TILDE, 8'h7F,
                 ell_pkg::CH_BSL, ell_pkg::CH_DOLLAR, ell_pkg::CH_BEL, ell_pkg::CH_BS,
                 ell_pkg::CH_FF, ell_pkg::CH_CR, ell_pkg::CH_TAB, ell_pkg::CH_VT, 8'h41};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width, every escape class
    foreach (directed[k])
      send_item(ell_pkg::KIND_CHAR, directed[k]);
    send_item(ell_pkg::KIND_EOL, 8'hA5);
    drain();

    // narrowest width: fold at column zero, piece wider than width
    set_wrap(16'd1);
    send_item(ell_pkg::KIND_CHAR, 8'h41);
    send_item(ell_pkg::KIND_CHAR, 8'h42);
    send_item(ell_pkg::KIND_CHAR, 8'h80);
    send_item(ell_pkg::KIND_EOL, 8'h00);
    send_item(ell_pkg::KIND_CHAR, 8'h00);
    drain();

    for (p = 0; p < 6; p++) begin
      gap_pct   = (p == 2 || p == 5) ? 0 : $urandom_range(5, 40);
      stall_pct = (p == 1 || p == 5) ? 0 : $urandom_range(5, 40);
      case (p)
        0: set_wrap(ell_pkg::col_t'($urandom_range(1, 8)));
        1: set_wrap(16'hFFFF);
        2: set_wrap(16'd0);
        3: set_wrap(ell_pkg::WRAP_RESET);
        4: set_wrap(16'd3);
        default: set_wrap(ell_pkg::col_t'($urandom_range(2, 16)));
      endcase
      if (p == 3)
        run_lines(35, 60);
      else
        run_lines(22, 10);
      drain();
    end

    repeat (20) @(posedge clk);
    if (board.pending.size() != 0) begin
      board.errors++;
      $display("%0t: expected %0d more listing bytes, got none", $time,
               board.pending.size());
    end
    $display("Covered %0d line items over %0d wrap widths: %0d listing bytes checked,",
             board.items, widths_set, board.bytes_seen);
    $display("%0d folds, zero and full-scale widths, widths changed mid-line.", board.folds);
    if (board.errors == 0)
      $display("[escaped_line_lister] OK");
    else
      $display("[escaped_line_lister] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[escaped_line_lister] ERROR");
    $finish;
  end

endmodule

// File: escaped_line_lister.f
src/ell_pkg.sv
src/ell_encode.sv
src/ell_emit.sv
src/escaped_line_lister.sv
test/tb_escaped_line_lister.sv
